// ===== hdl/cubic_bezier_eval_arc_length_defines.svh =====
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator: assertion macros
// Shared concurrent assertion shorthands for the curve unit.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EVAL_ARC_LENGTH_DEFINES_SVH
`define CUBIC_BEZIER_EVAL_ARC_LENGTH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CBEZ_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define CBEZ_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cbez_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator package
// Opcodes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package cbez_pkg;

	localparam int COORD_W   = 32;
	localparam int CFG_IDX_W = 4;
	localparam int NUM_REGS  = 8;

	// chord length: floor sqrt of a 65-bit sum of squares
	localparam int CHORD_W = 33;

	typedef enum logic [1:0] {
		OP_POINT   = 2'd0,
		OP_LENGTH  = 2'd1,
		OP_AT_DIST = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_GUIDE1_X = 3'd2;
	localparam logic [2:0] REG_GUIDE1_Y = 3'd3;
	localparam logic [2:0] REG_GUIDE2_X = 3'd4;
	localparam logic [2:0] REG_GUIDE2_Y = 3'd5;
	localparam logic [2:0] REG_END_X    = 3'd6;
	localparam logic [2:0] REG_END_Y    = 3'd7;

endpackage

// ===== hdl/cbez_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one curve request item.
// ----------------------------------------------------------------------------
interface cbez_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [16:0]        param_t;
	logic signed [31:0] distance;
	logic [8:0]         subdivisions;

	modport source (output valid, op, param_t, distance, subdivisions, input ready);
	modport sink (input valid, op, param_t, distance, subdivisions, output ready);
endinterface

// ===== hdl/cbez_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one curve result item.
// ----------------------------------------------------------------------------
interface cbez_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0]        length;

	modport source (output valid, pos_x, pos_y, length, input ready);
	modport sink (input valid, pos_x, pos_y, length, output ready);
endinterface

// ===== hdl/cbez_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbez_div
	import cbez_pkg::*;
#(
	parameter int DW = 25,
	parameter int QW = 17,
	parameter int CW = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [CHORD_W-1:0] rem_init,
	input  logic [DW-1:0]      dvd_init,
	input  logic [CW-1:0]      steps,
	input  logic [CHORD_W-1:0] divisor,
	output logic               done,
	output logic [QW-1:0]      quo
);

	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic [CHORD_W-1:0] r_q;
	logic [CHORD_W-1:0] dvs_q;
	logic [DW-1:0]      dvd_q;
	logic [QW-1:0]      quo_q;
	logic [CHORD_W:0]   r2;
	logic               ge;

	// trial subtract of the shifted partial remainder
	assign r2 = {r_q, dvd_q[DW-1]};
	assign ge = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= rem_init;
			dvd_q <= dvd_init;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			r_q   <= ge ? CHORD_W'(r2 - {1'b0, dvs_q}) : r2[CHORD_W-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/cbez_isqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 65-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module cbez_isqrt
	import cbez_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [64:0]        val,
	output logic               done,
	output logic [CHORD_W-1:0] root
);

	logic [5:0]         cnt_q;
	logic               done_q;
	logic [65:0]        src_q;
	logic [33:0]        rem_q;
	logic [CHORD_W-1:0] root_q;
	logic [35:0]        rem2;
	logic [35:0]        trial;
	logic               ge;

	// bring down the next bit pair, test 4*root+1
	assign rem2  = {rem_q, src_q[65:64]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd33;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= {1'b0, val};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			src_q  <= {src_q[63:0], 2'b00};
			rem_q  <= ge ? 34'(rem2 - trial) : rem2[33:0];
			root_q <= {root_q[CHORD_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/cubic_bezier_eval_arc_length.sv =====
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator with chord-length arc walk
// Point at t, approximate length, and point at distance on a 2D cubic curve.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | op, param_t, distance, subdivisions
//  rsp     | out | pos_x, pos_y, length
//  cfg     | in  | cfg_we, cfg_index, cfg_wdata (8 control point coordinates)
//
//  One item at a time; req.ready is low from accept until the result is taken.
//  Point at t: 12 lerps, each a multiply state then an add state, on one multiplier.
//  Length / point at distance: per chord, an NW-step divide for t (NW =
//  clog2(MAX_SUBDIVISIONS+1) + FRACTION_BITS, 25 at defaults), 12 lerps, two
//  squares and the 33-step square root; and a FRACTION_BITS-step divide and two lerps at
//  the crossing chord. Reset clears control and control points; no clearing pass.
// ----------------------------------------------------------------------------
`include "cubic_bezier_eval_arc_length_defines.svh"

module cubic_bezier_eval_arc_length
	import cbez_pkg::*;
#(
	parameter int MAX_SUBDIVISIONS = 256,
	parameter int FRACTION_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_wdata,
	cbez_req_if.sink             req,
	cbez_rsp_if.source           rsp
);

	localparam int F      = FRACTION_BITS;
	localparam int TW     = F + 1;
	localparam int IW     = $clog2(MAX_SUBDIVISIONS + 1);
	localparam int NW     = IW + F;
	localparam int DCW    = $clog2(NW + 1);
	localparam int SHL    = (F >= 16) ? F - 16 : 0;
	localparam int SHR    = (F < 16) ? 16 - F : 0;
	localparam int HALF_T = (1 << SHR) >> 1;
	localparam int HALF_F = 1 << (F - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_TGO, S_TWAIT, S_MUL, S_ADD, S_SQX, S_SQY, S_SQGO,
		S_SQWAIT, S_FGO, S_FWAIT, S_FMUL, S_FADD, S_OUT
	} state_t;

	// control point registers
	logic signed [COORD_W-1:0] cfg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				cfg_q[r] <= '0;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[2:0]] <= cfg_wdata;
		end
	end

	state_t                    state_q;
	op_t                       op_q;
	logic [IW-1:0]             n_q, i_q;
	logic [TW-1:0]             t_q, frac_q;
	logic [2:0]                k_q;
	logic                      ax_q;
	logic signed [COORD_W-1:0] lv_q [5];
	logic signed [COORD_W-1:0] cx_q, cy_q, nx_q, ny_q;
	logic [31:0]               rem_q, len_q;
	logic [CHORD_W-1:0]        d_q;
	logic [63:0]               acc_q;
	logic signed [65:0]        prod_q;
	logic signed [COORD_W-1:0] pos_x_q, pos_y_q;

	// request decode
	logic [16:0]   pt_sat;
	logic [41:0]   t_wide;
	logic [TW-1:0] t_conv;
	logic [IW-1:0] n_sat;

	always_comb begin
		pt_sat = (req.param_t > 17'd65536) ? 17'd65536 : req.param_t;
		if (F >= 16) begin
			t_wide = 42'(pt_sat) << SHL;
		end else begin
			t_wide = (42'(pt_sat) + 42'(HALF_T)) >> SHR;
		end
		t_conv = t_wide[TW-1:0];
		n_sat  = (32'(req.subdivisions) > 32'(MAX_SUBDIVISIONS)) ?
			IW'(MAX_SUBDIVISIONS) : IW'(req.subdivisions);
	end

	// lerp operand select: de Casteljau level or final chord interpolation
	logic signed [COORD_W-1:0] p0, p1, p2, p3, lo, hi;
	logic [TW-1:0]             f_sel;

	always_comb begin
		p0 = ax_q ? cfg_q[REG_START_Y]  : cfg_q[REG_START_X];
		p1 = ax_q ? cfg_q[REG_GUIDE1_Y] : cfg_q[REG_GUIDE1_X];
		p2 = ax_q ? cfg_q[REG_GUIDE2_Y] : cfg_q[REG_GUIDE2_X];
		p3 = ax_q ? cfg_q[REG_END_Y]    : cfg_q[REG_END_X];
		if (state_q == S_FMUL || state_q == S_FADD) begin
			lo    = ax_q ? cy_q : cx_q;
			hi    = ax_q ? ny_q : nx_q;
			f_sel = frac_q;
		end else begin
			f_sel = t_q;
			unique case (k_q)
				3'd0: begin lo = p0; hi = p1; end
				3'd1: begin lo = p1; hi = p2; end
				3'd2: begin lo = p2; hi = p3; end
				3'd3: begin lo = lv_q[0]; hi = lv_q[1]; end
				3'd4: begin lo = lv_q[1]; hi = lv_q[2]; end
				default: begin lo = lv_q[3]; hi = lv_q[4]; end
			endcase
		end
	end

	// shared multiplier operands
	logic signed [32:0]        diff, dx, dy, mul_a, mul_b;
	logic signed [65:0]        rsum, rnd;
	logic signed [COORD_W-1:0] lerp_res;

	always_comb begin
		diff = {hi[31], hi} - {lo[31], lo};
		dx   = {nx_q[31], nx_q} - {cx_q[31], cx_q};
		dy   = {ny_q[31], ny_q} - {cy_q[31], cy_q};
		unique case (state_q)
			S_SQX:   begin mul_a = dx; mul_b = dx; end
			S_SQY:   begin mul_a = dy; mul_b = dy; end
			default: begin mul_a = diff; mul_b = $signed(33'(f_sel)); end
		endcase
		rsum     = prod_q + 66'(HALF_F);
		rnd      = rsum >>> F;
		lerp_res = lo + rnd[31:0];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// divider: step parameter or crossing fraction
	logic               div_start, div_done;
	logic [CHORD_W-1:0] div_rem, div_dvs;
	logic [NW-1:0]      div_dvd;
	logic [DCW-1:0]     div_steps;
	logic [TW-1:0]      div_quo;

	always_comb begin
		div_start = (state_q == S_TGO) || (state_q == S_FGO);
		if (state_q == S_FGO) begin
			div_rem   = CHORD_W'(rem_q);
			div_dvd   = '0;
			div_steps = DCW'(F);
			div_dvs   = d_q;
		end else begin
			div_rem   = '0;
			div_dvd   = (NW'(i_q) << F) + NW'(n_q >> 1);
			div_steps = DCW'(NW);
			div_dvs   = CHORD_W'(n_q);
		end
	end

	cbez_div #(.DW(NW), .QW(TW), .CW(DCW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.dvd_init (div_dvd),
		.steps    (div_steps),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (div_quo)
	);

	// chord length
	logic               sq_start, sq_done;
	logic [64:0]        sq_val;
	logic [CHORD_W-1:0] chord;

	assign sq_start = state_q == S_SQGO;
	assign sq_val   = {1'b0, acc_q} + {1'b0, prod_q[63:0]};

	cbez_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    (sq_val),
		.done   (sq_done),
		.root   (chord)
	);

	logic [33:0] lsum;
	assign lsum = {2'b00, len_q} + {1'b0, chord};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_NONE;
			len_q   <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= op_t'(req.op);
						n_q     <= n_sat;
						i_q     <= IW'(1);
						t_q     <= t_conv;
						len_q   <= '0;
						rem_q   <= req.distance;
						cx_q    <= cfg_q[REG_START_X];
						cy_q    <= cfg_q[REG_START_Y];
						k_q     <= 3'd0;
						ax_q    <= 1'b0;
						pos_x_q <= '0;
						pos_y_q <= '0;
						unique case (op_t'(req.op))
							OP_POINT: state_q <= S_MUL;
							OP_LENGTH: state_q <= (n_sat == '0) ? S_OUT : S_TGO;
							OP_AT_DIST: begin
								if (req.distance <= 0) begin
									pos_x_q <= cfg_q[REG_START_X];
									pos_y_q <= cfg_q[REG_START_Y];
									state_q <= S_OUT;
								end else if (n_sat == '0) begin
									pos_x_q <= cfg_q[REG_END_X];
									pos_y_q <= cfg_q[REG_END_Y];
									state_q <= S_OUT;
								end else begin
									state_q <= S_TGO;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_TGO: state_q <= S_TWAIT;
				S_TWAIT: begin
					if (div_done) begin
						t_q     <= div_quo;
						k_q     <= 3'd0;
						ax_q    <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					if (k_q != 3'd5) begin
						lv_q[k_q] <= lerp_res;
						k_q       <= k_q + 3'd1;
						state_q   <= S_MUL;
					end else if (!ax_q) begin
						nx_q    <= lerp_res;
						ax_q    <= 1'b1;
						k_q     <= 3'd0;
						state_q <= S_MUL;
					end else if (op_q == OP_POINT) begin
						pos_x_q <= nx_q;
						pos_y_q <= lerp_res;
						state_q <= S_OUT;
					end else begin
						ny_q    <= lerp_res;
						state_q <= S_SQX;
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					acc_q   <= prod_q[63:0];
					state_q <= S_SQGO;
				end
				S_SQGO: state_q <= S_SQWAIT;
				S_SQWAIT: begin
					if (sq_done) begin
						if (op_q == OP_AT_DIST && chord > CHORD_W'(rem_q)) begin
							d_q     <= chord;
							state_q <= S_FGO;
						end else begin
							if (op_q == OP_LENGTH) begin
								len_q <= (lsum[33:32] != 2'b00) ? '1 : lsum[31:0];
							end else begin
								rem_q <= rem_q - chord[31:0];
							end
							cx_q <= nx_q;
							cy_q <= ny_q;
							if (i_q == n_q) begin
								if (op_q == OP_AT_DIST) begin
									pos_x_q <= cfg_q[REG_END_X];
									pos_y_q <= cfg_q[REG_END_Y];
								end
								state_q <= S_OUT;
							end else begin
								i_q     <= i_q + IW'(1);
								state_q <= S_TGO;
							end
						end
					end
				end
				S_FGO: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (div_done) begin
						frac_q  <= div_quo;
						ax_q    <= 1'b0;
						state_q <= S_FMUL;
					end
				end
				S_FMUL: state_q <= S_FADD;
				S_FADD: begin
					if (!ax_q) begin
						pos_x_q <= lerp_res;
						ax_q    <= 1'b1;
						state_q <= S_FMUL;
					end else begin
						pos_y_q <= lerp_res;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready  = state_q == S_IDLE;
	assign rsp.valid  = state_q == S_OUT;
	assign rsp.pos_x  = pos_x_q;
	assign rsp.pos_y  = pos_y_q;
	assign rsp.length = len_q;

	`CBEZ_ASSERT_IMP(a_busy_while_out, clk, arst_n, rsp.valid, !req.ready, "accepting while result pending")
	`CBEZ_ASSERT_NXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "second item accepted while busy")
	`CBEZ_ASSERT_IMP(a_len_only_op1, clk, arst_n, rsp.valid && op_q != OP_LENGTH, rsp.length == '0, "length nonzero outside length op")
	`CBEZ_ASSERT_IMP(a_pos_zero_op1, clk, arst_n, rsp.valid && (op_q == OP_LENGTH || op_q == OP_NONE), rsp.pos_x == '0 && rsp.pos_y == '0, "point nonzero for length or unused op")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier evaluator testbench
// Drives point, length, point-at-distance and unused-op requests over several
// sets of control points, predicts each result in fixed point and checks every field.
// ----------------------------------------------------------------------------
module testbench;
	import cbez_pkg::*;

	typedef struct {
		op_t         op;
		logic [16:0] param_t;
		logic [31:0] distance;
		logic [8:0]  subdivisions;
	} curve_req_t;

	typedef struct {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] length;
	} curve_res_t;

	localparam int MAX_N = 256;
	localparam int FB    = 16;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_wdata;

	cbez_req_if req_ch();
	cbez_rsp_if rsp_ch();

	cubic_bezier_eval_arc_length i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req(req_ch), .rsp(rsp_ch)
	);

	curve_req_t pending_reqs[$];
	curve_res_t expected_res[$];
	longint     ctrl_pts[8];
	int         mismatch_cnt = 0;
	bit         calm = 0;

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// ---------------- fixed point curve math ----------------
	function automatic longint lerp_fx(longint a, longint b, longint f);
		longint p;
		p = (b - a) * f;
		return a + ((p + (64'sd1 <<< (FB - 1))) >>> FB);
	endfunction

	function automatic longint casteljau(longint p0, longint p1, longint p2, longint p3,
			longint t);
		longint a, b, c, d, e;
		a = lerp_fx(p0, p1, t);
		b = lerp_fx(p1, p2, t);
		c = lerp_fx(p2, p3, t);
		d = lerp_fx(a, b, t);
		e = lerp_fx(b, c, t);
		return lerp_fx(d, e, t);
	endfunction

	function automatic longint curve_x(longint t);
		return casteljau(ctrl_pts[REG_START_X], ctrl_pts[REG_GUIDE1_X],
			ctrl_pts[REG_GUIDE2_X], ctrl_pts[REG_END_X], t);
	endfunction

	function automatic longint curve_y(longint t);
		return casteljau(ctrl_pts[REG_START_Y], ctrl_pts[REG_GUIDE1_Y],
			ctrl_pts[REG_GUIDE2_Y], ctrl_pts[REG_END_Y], t);
	endfunction

	function automatic longint chord_len(longint x0, longint y0, longint x1, longint y1);
		longint      dx, dy;
		logic [65:0] ax, ay, sum;
		logic [69:0] sq;
		logic [33:0] root, trial;
		dx = x1 - x0;
		dy = y1 - y0;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sum = ax * ax + ay * ay;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (34'd1 << b);
			sq = {36'd0, trial} * {36'd0, trial};
			if (sq <= {4'd0, sum})
				root = trial;
		end
		return longint'(root);
	endfunction

	function automatic longint chord_t(longint i, longint n);
		return ((i << FB) + (n >> 1)) / n;
	endfunction

	function automatic curve_res_t predict_curve(curve_req_t r);
		curve_res_t res;
		longint     n, px, py, len, cx, cy, nx, ny, total, remain, d, f, t;
		bit         found;
		n = (r.subdivisions > MAX_N) ? MAX_N : r.subdivisions;
		px = 0;
		py = 0;
		len = 0;
		case (r.op)
			OP_POINT: begin
				t = (r.param_t > 17'd65536) ? 65536 : r.param_t;
				px = curve_x(t);
				py = curve_y(t);
			end
			OP_LENGTH: begin
				cx = ctrl_pts[REG_START_X];
				cy = ctrl_pts[REG_START_Y];
				for (longint i = 1; i <= n; i++) begin
					t = chord_t(i, n);
					nx = curve_x(t);
					ny = curve_y(t);
					len += chord_len(cx, cy, nx, ny);
					if (len > 64'hFFFF_FFFF)
						len = 64'hFFFF_FFFF;
					cx = nx;
					cy = ny;
				end
			end
			OP_AT_DIST: begin
				if ($signed(r.distance) <= 0) begin
					px = ctrl_pts[REG_START_X];
					py = ctrl_pts[REG_START_Y];
				end else begin
					cx = ctrl_pts[REG_START_X];
					cy = ctrl_pts[REG_START_Y];
					total = 0;
					found = 0;
					for (longint i = 1; i <= n && !found; i++) begin
						remain = longint'($signed(r.distance)) - total;
						t = chord_t(i, n);
						nx = curve_x(t);
						ny = curve_y(t);
						d = chord_len(cx, cy, nx, ny);
						if (d > remain) begin
							f = (remain << FB) / d;
							px = lerp_fx(cx, nx, f);
							py = lerp_fx(cy, ny, f);
							found = 1;
						end else begin
							total += d;
							cx = nx;
							cy = ny;
						end
					end
					if (!found) begin
						px = ctrl_pts[REG_END_X];
						py = ctrl_pts[REG_END_Y];
					end
				end
			end
			default: ;
		endcase
		res.pos_x = px[31:0];
		res.pos_y = py[31:0];
		res.length = len[31:0];
		return res;
	endfunction

	// ---------------- request driver ----------------
	int req_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		curve_req_t nxt;
		logic       nxt_valid;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= OP_POINT;
			req_ch.param_t <= '0;
			req_ch.distance <= '0;
			req_ch.subdivisions <= '0;
			req_gap <= 0;
		end else begin
			nxt_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				nxt.op = op_t'(req_ch.op);
				nxt.param_t = req_ch.param_t;
				nxt.distance = req_ch.distance;
				nxt.subdivisions = req_ch.subdivisions;
				expected_res.push_back(predict_curve(nxt));
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (req_gap > 0) begin
					req_gap <= req_gap - 1;
				end else if (pending_reqs.size() > 0) begin
					nxt = pending_reqs.pop_front();
					req_ch.op <= nxt.op;
					req_ch.param_t <= nxt.param_t;
					req_ch.distance <= nxt.distance;
					req_ch.subdivisions <= nxt.subdivisions;
					nxt_valid = 1'b1;
					if (!calm && $urandom_range(0, 3) == 0)
						req_gap <= $urandom_range(1, 17);
				end
			end
			req_ch.valid <= nxt_valid;
		end
	end

	// ---------------- result monitor ----------------
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_cnt++;
	endtask

	int rsp_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		curve_res_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_res.size() == 0) begin
					report_mismatch("unexpected item", rsp_ch.length, '0);
				end else begin
					want = expected_res.pop_front();
					if (rsp_ch.pos_x !== want.pos_x)
						report_mismatch("pos_x", rsp_ch.pos_x, want.pos_x);
					if (rsp_ch.pos_y !== want.pos_y)
						report_mismatch("pos_y", rsp_ch.pos_y, want.pos_y);
					if (rsp_ch.length !== want.length)
						report_mismatch("length", rsp_ch.length, want.length);
				end
			end
			// random stall bursts on the result side
			if (rsp_stall > 0) begin
				rsp_stall <= rsp_stall - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= $urandom_range(0, 16);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx < NUM_REGS)
			ctrl_pts[idx] = longint'($signed(val));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_req(op_t op, logic [16:0] pt, logic [31:0] dist_val, logic [8:0] n);
		curve_req_t r;
		r.op = op;
		r.param_t = pt;
		r.distance = dist_val;
		r.subdivisions = n;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_res.size() > 0 || req_ch.valid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic add_random_reqs(int count);
		logic [8:0]  n;
		logic [31:0] dist_val;
		for (int k = 0; k < count; k++) begin
			n = ($urandom_range(0, 29) == 0) ? 9'($urandom_range(256, 511))
				: 9'($urandom_range(0, 16));
			case ($urandom_range(0, 3))
				0: dist_val = $urandom;
				1: dist_val = $urandom_range(0, 32'h0100_0000);
				2: dist_val = $urandom_range(0, 32'h7FFF_FFFF);
				default: dist_val = -$urandom_range(0, 1000);
			endcase
			add_req(op_t'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)), dist_val, n);
		end
	endtask

	initial begin
		logic [31:0] pts[8];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		foreach (ctrl_pts[i])
			ctrl_pts[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// degenerate curve at reset
		add_req(OP_POINT, 17'd32768, 32'd0, 9'd0);
		add_req(OP_LENGTH, 17'd0, 32'd0, 9'd4);
		add_req(OP_AT_DIST, 17'd0, 32'd100, 9'd4);
		wait_drained();

		// a plain curve: the directed special cases
		pts = '{32'h0, 32'h0, 32'h0001_0000, 32'h0003_0000,
			32'h0004_0000, 32'hFFFE_0000, 32'h0005_0000, 32'h0001_0000};
		foreach (pts[i])
			write_reg(CFG_IDX_W'(i), pts[i]);
		write_reg(4'd9, 32'hDEAD_BEEF);  // out of range, ignored
		write_reg(4'd15, 32'h1234_5678);
		add_req(OP_POINT, 17'd0, 32'd0, 9'd0);
		add_req(OP_POINT, 17'd65536, 32'd0, 9'd0);
		add_req(OP_POINT, 17'h1FFFF, 32'hFFFF_FFFF, 9'h1FF);  // t above one
		add_req(OP_POINT, 17'd12345, 32'd0, 9'd1);
		add_req(OP_LENGTH, 17'd0, 32'd0, 9'd0);                // zero chords
		add_req(OP_LENGTH, 17'd0, 32'd0, 9'd1);
		add_req(OP_LENGTH, 17'd0, 32'd0, 9'd7);
		add_req(OP_LENGTH, 17'd0, 32'd0, 9'h1FF);              // too many chords
		add_req(OP_AT_DIST, 17'd0, 32'd0, 9'd8);               // zero distance
		add_req(OP_AT_DIST, 17'd0, 32'h8000_0000, 9'd8);       // most negative
		add_req(OP_AT_DIST, 17'd0, 32'h0002_8000, 9'd8);
		add_req(OP_AT_DIST, 17'd0, 32'h7FFF_FFFF, 9'd8);       // past the end
		add_req(OP_AT_DIST, 17'd0, 32'd1, 9'd0);               // zero chords
		add_req(OP_AT_DIST, 17'd0, 32'h0001_0000, 9'd256);
		add_req(OP_NONE, 17'h1FFFF, 32'hFFFF_FFFF, 9'h1FF);
		add_req(OP_NONE, 17'd0, 32'd0, 9'd0);
		wait_drained();

		// extreme coordinates, then random curves; no idling in the last phase
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: foreach (pts[i]) pts[i] = 32'h7FFF_FFFF;
				1: foreach (pts[i]) pts[i] = (i < 4) ? 32'h8000_0000 : 32'h7FFF_FFFF;
				2: foreach (pts[i]) pts[i] = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				3: foreach (pts[i]) pts[i] = $urandom;
				default: foreach (pts[i]) pts[i] = $signed($urandom_range(0, 32'h00FF_FFFF))
					- 32'sh0080_0000;
			endcase
			foreach (pts[i])
				write_reg(CFG_IDX_W'(i), pts[i]);
			if (phase == 5)
				calm = 1;
			add_random_reqs(phase < 3 ? 10 : 25);
			wait_drained();
		end

		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
